/* sv/emc_pkg.sv */
// emc_pkg: shared types, codes and sizes for the event match confusion counter
// holds the request and category codes, the beat structs and the sequencer states
// no dependencies
package emc_pkg;

  localparam int MAX_POINTS = 256;
  localparam int PT_AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PT_CW      = $clog2(MAX_POINTS + 1);
  localparam int TIME_W     = 64;
  localparam int TOL_W      = 16;
  localparam int CNT_W      = 32;
  localparam int REQ_W      = 3;
  localparam int CAT_W      = 3;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(450);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  localparam logic [REQ_W-1:0] REQ_CLR_PTS  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CLR_ALL  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADD_DET  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ADD_REF  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLASSIFY = 3'd4;

  localparam logic [CAT_W-1:0] CAT_TP   = 3'd0;
  localparam logic [CAT_W-1:0] CAT_FP   = 3'd1;
  localparam logic [CAT_W-1:0] CAT_FN   = 3'd2;
  localparam logic [CAT_W-1:0] CAT_TN   = 3'd3;
  localparam logic [CAT_W-1:0] CAT_NONE = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic [CAT_W-1:0] category;
    logic             table_full;
    logic [CNT_W-1:0] true_pos_count;
    logic [CNT_W-1:0] false_pos_count;
    logic [CNT_W-1:0] false_neg_count;
    logic [CNT_W-1:0] true_neg_count;
  } out_item_t;

  typedef struct packed {
    logic det_hit;
    logic det_near;
    logic ref_hit;
    logic ref_near;
  } match_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DET,
    ST_REF,
    ST_FIN
  } emc_state_t;

endpackage

/* sv/event_match_confusion_counter_unit.sv */
// event_match_confusion_counter_unit: point tables, scan sequencer and class counters
// depends on emc_pkg for codes, beat structs and the state type
//
// usage
//   input beats are commands: a beat is taken at a clock edge with start high and
//   busy low. in_data carries req_type and time_value.
//   clear and add commands finish at once: the result strobe out_valid rises in the
//   cycle after the beat and busy never goes high.
//   a classify walks the detected table, then the reference table, one entry per
//   cycle through a single compare unit (exact match plus |sample - point| <= tol).
//   busy stays high through the walk of both tables and the final ST_FIN step; the
//   result strobe comes in the first cycle with busy low, the same cycle in which
//   the next command may already be taken.
//   every command gives exactly one result beat, shown for one cycle only; the
//   receiver has no way to stall it.
//   cfg_data sets the tolerance; cfg_ready is always high, and writes are only
//   expected while no command is in flight.
//   reset empties both tables, zeroes the four counters and loads tolerance 450.
//   table contents are not cleared; only entries below the fill counts are read.
module event_match_confusion_counter_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  emc_pkg::in_item_t            in_data,
  output logic                         out_valid,
  output emc_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [emc_pkg::TOL_W-1:0]    cfg_data
);

  localparam int AW = emc_pkg::PT_AW;
  localparam int CW = emc_pkg::PT_CW;
  localparam int TW = emc_pkg::TIME_W;
  localparam int NW = emc_pkg::CNT_W;

  // point memories
  logic [TW-1:0] det_mem [emc_pkg::MAX_POINTS];
  logic [TW-1:0] ref_mem [emc_pkg::MAX_POINTS];
  logic [TW-1:0] det_rdata_r;
  logic [TW-1:0] ref_rdata_r;

  emc_pkg::emc_state_t   state_r, state_nxt;
  logic [CW-1:0]         det_used_r, det_used_nxt;
  logic [CW-1:0]         ref_used_r, ref_used_nxt;
  logic [CW-1:0]         addr_r, addr_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic                  rd_tab_r, rd_tab_nxt;
  logic [TW-1:0]         sample_r, sample_nxt;
  emc_pkg::match_flags_t flags_r, flags_nxt;
  logic [emc_pkg::TOL_W-1:0] tol_r, tol_nxt;
  logic [NW-1:0]         tp_r, tp_nxt;
  logic [NW-1:0]         fp_r, fp_nxt;
  logic [NW-1:0]         fn_r, fn_nxt;
  logic [NW-1:0]         tn_r, tn_nxt;
  logic                  out_valid_r, out_valid_nxt;
  emc_pkg::out_item_t    out_r, out_nxt;

  logic                  accept;
  logic                  det_wr, ref_wr;

  // shared compare unit
  logic [TW-1:0] cmp_p;
  logic [TW:0]   diff_vp;
  logic [TW-1:0] diff_pv;
  logic [TW-1:0] gap;
  logic          cmp_eq;
  logic          cmp_near;

  function automatic logic [NW-1:0] sat_inc(input logic [NW-1:0] c);
    sat_inc = (c == emc_pkg::CNT_MAX) ? c : c + NW'(1);
  endfunction

  assign busy      = (state_r != emc_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cmp_p    = rd_tab_r ? ref_rdata_r : det_rdata_r;
  assign diff_vp  = {1'b0, sample_r} - {1'b0, cmp_p};
  assign diff_pv  = cmp_p - sample_r;
  assign gap      = diff_vp[TW] ? diff_pv : diff_vp[TW-1:0];
  assign cmp_eq   = (sample_r == cmp_p);
  // clamped window [p - tol, p + tol] is the same as distance <= tol
  assign cmp_near = (gap[TW-1:emc_pkg::TOL_W] == '0) && (gap[emc_pkg::TOL_W-1:0] <= tol_r);

  assign det_wr = accept && (in_data.req_type == emc_pkg::REQ_ADD_DET) &&
                  (det_used_r != CW'(emc_pkg::MAX_POINTS));
  assign ref_wr = accept && (in_data.req_type == emc_pkg::REQ_ADD_REF) &&
                  (ref_used_r != CW'(emc_pkg::MAX_POINTS));

  always_ff @(posedge clk) begin
    if (det_wr) begin
      det_mem[det_used_r[AW-1:0]] <= in_data.time_value;
    end
    det_rdata_r <= det_mem[addr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ref_wr) begin
      ref_mem[ref_used_r[AW-1:0]] <= in_data.time_value;
    end
    ref_rdata_r <= ref_mem[addr_r[AW-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    det_used_nxt  = det_used_r;
    ref_used_nxt  = ref_used_r;
    addr_nxt      = addr_r;
    rd_vld_nxt    = 1'b0;
    rd_tab_nxt    = rd_tab_r;
    sample_nxt    = sample_r;
    flags_nxt     = flags_r;
    tol_nxt       = tol_r;
    tp_nxt        = tp_r;
    fp_nxt        = fp_r;
    fn_nxt        = fn_r;
    tn_nxt        = tn_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    if (cfg_valid && cfg_ready) begin
      tol_nxt = cfg_data;
    end

    // fold the beat read last cycle into the flags of its table
    if (rd_vld_r) begin
      if (rd_tab_r) begin
        flags_nxt.ref_hit  = flags_r.ref_hit  | cmp_eq;
        flags_nxt.ref_near = flags_r.ref_near | cmp_near;
      end else begin
        flags_nxt.det_hit  = flags_r.det_hit  | cmp_eq;
        flags_nxt.det_near = flags_r.det_near | cmp_near;
      end
    end

    unique case (state_r)
      emc_pkg::ST_IDLE: begin
        if (accept) begin
          out_nxt.category   = emc_pkg::CAT_NONE;
          out_nxt.table_full = 1'b0;
          unique case (in_data.req_type)
            emc_pkg::REQ_CLR_PTS: begin
              det_used_nxt = '0;
              ref_used_nxt = '0;
            end
            emc_pkg::REQ_CLR_ALL: begin
              det_used_nxt = '0;
              ref_used_nxt = '0;
              tp_nxt       = '0;
              fp_nxt       = '0;
              fn_nxt       = '0;
              tn_nxt       = '0;
            end
            emc_pkg::REQ_ADD_DET: begin
              if (det_wr) begin
                det_used_nxt = det_used_r + CW'(1);
              end else begin
                out_nxt.table_full = 1'b1;
              end
            end
            emc_pkg::REQ_ADD_REF: begin
              if (ref_wr) begin
                ref_used_nxt = ref_used_r + CW'(1);
              end else begin
                out_nxt.table_full = 1'b1;
              end
            end
            emc_pkg::REQ_CLASSIFY: begin
              state_nxt  = emc_pkg::ST_DET;
              sample_nxt = in_data.time_value;
              flags_nxt  = '0;
              addr_nxt   = '0;
            end
            default: begin
            end
          endcase
          if (in_data.req_type != emc_pkg::REQ_CLASSIFY) begin
            out_valid_nxt           = 1'b1;
            out_nxt.true_pos_count  = tp_nxt;
            out_nxt.false_pos_count = fp_nxt;
            out_nxt.false_neg_count = fn_nxt;
            out_nxt.true_neg_count  = tn_nxt;
          end
        end
      end
      emc_pkg::ST_DET: begin
        if (addr_r < det_used_r) begin
          rd_vld_nxt = 1'b1;
          rd_tab_nxt = 1'b0;
          addr_nxt   = addr_r + CW'(1);
        end else begin
          state_nxt = emc_pkg::ST_REF;
          addr_nxt  = '0;
        end
      end
      emc_pkg::ST_REF: begin
        if (addr_r < ref_used_r) begin
          rd_vld_nxt = 1'b1;
          rd_tab_nxt = 1'b1;
          addr_nxt   = addr_r + CW'(1);
        end else begin
          state_nxt = emc_pkg::ST_FIN;
        end
      end
      emc_pkg::ST_FIN: begin
        state_nxt          = emc_pkg::ST_IDLE;
        out_valid_nxt      = 1'b1;
        out_nxt.table_full = 1'b0;
        if (flags_r.det_hit) begin
          if (flags_r.ref_near) begin
            out_nxt.category = emc_pkg::CAT_TP;
            tp_nxt           = sat_inc(tp_r);
          end else begin
            out_nxt.category = emc_pkg::CAT_FP;
            fp_nxt           = sat_inc(fp_r);
          end
        end else if (flags_r.ref_hit && !flags_r.det_near) begin
          out_nxt.category = emc_pkg::CAT_FN;
          fn_nxt           = sat_inc(fn_r);
        end else begin
          out_nxt.category = emc_pkg::CAT_TN;
          tn_nxt           = sat_inc(tn_r);
        end
        out_nxt.true_pos_count  = tp_nxt;
        out_nxt.false_pos_count = fp_nxt;
        out_nxt.false_neg_count = fn_nxt;
        out_nxt.true_neg_count  = tn_nxt;
      end
      default: begin
        state_nxt = emc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= emc_pkg::ST_IDLE;
      det_used_r  <= '0;
      ref_used_r  <= '0;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      rd_tab_r    <= 1'b0;
      flags_r     <= '0;
      tol_r       <= emc_pkg::TOL_RESET;
      tp_r        <= '0;
      fp_r        <= '0;
      fn_r        <= '0;
      tn_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      det_used_r  <= det_used_nxt;
      ref_used_r  <= ref_used_nxt;
      addr_r      <= addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_tab_r    <= rd_tab_nxt;
      flags_r     <= flags_nxt;
      tol_r       <= tol_nxt;
      tp_r        <= tp_nxt;
      fp_r        <= fp_nxt;
      fn_r        <= fn_nxt;
      tn_r        <= tn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    out_r    <= out_nxt;
  end

endmodule

/* sv/emc_checker.sv */
// emc_checker: port-level checks on the event match confusion counter
// depends on emc_pkg; bound to event_match_confusion_counter_unit at the end
module emc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input emc_pkg::in_item_t         in_data,
  input logic                      out_valid,
  input emc_pkg::out_item_t        out_data
);

  // a classify beat always starts a table walk
  a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.req_type == emc_pkg::REQ_CLASSIFY) |=> busy)
    else $error("classify beat did not raise busy");

  // any other command answers in the next cycle with no category
  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.req_type != emc_pkg::REQ_CLASSIFY)
    |=> out_valid && (out_data.category == emc_pkg::CAT_NONE) && !busy)
    else $error("command result missing or wrong");

  // a classify result lands only after the walk has ended
  a_class_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.category != emc_pkg::CAT_NONE) |-> !busy && $past(busy))
    else $error("classify result while walking");

  // a true positive leaves a nonzero counter
  a_tp_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.category == emc_pkg::CAT_TP) |-> (out_data.true_pos_count != '0))
    else $error("true positive with zero count");

endmodule

bind event_match_confusion_counter_unit emc_checker u_emc_checker (.*);
